[hdl/stpu_pkg.sv]
`timescale 1ns / 1ps

package stpu_pkg;

  // table geometry
  localparam int NUM_BLOCKS  = 64;
  localparam int BLOCK_WORDS = 4096;
  localparam int IDX_W       = $clog2(NUM_BLOCKS);
  localparam int OFF_W       = $clog2(BLOCK_WORDS);
  localparam int MARK_W      = $clog2(NUM_BLOCKS + 1);

  // beat field widths
  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 13;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int BIDX_W   = 6;
  localparam int OFFS_W   = 12;
  localparam int BASE_W   = 18;
  localparam int VIDX_W   = ADDR_W - OFF_W;
  localparam int CMP_W    = (OFF_W > SIZE_W) ? OFF_W : SIZE_W;

  localparam int IN_BITS  = CMD_W + ADDR_W + SIZE_W + MODE_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + BIDX_W + OFFS_W + BASE_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // mode bit positions
  localparam int MODE_READ   = 0;
  localparam int MODE_WRITE  = 1;
  localparam int MODE_MAPPED = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_RD_CHECK = 3'd0,
    CMD_WR_CHECK = 3'd1,
    CMD_ALLOC    = 3'd2,
    CMD_RESIZE   = 3'd3,
    CMD_CHPERM   = 3'd4,
    CMD_FREE     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_PROT    = 2'd2,
    ST_OOM     = 2'd3
  } status_e;

  // one descriptor entry in the ram
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [MODE_W-1:0] mode;
  } desc_t;

  // update request to the slot tracker
  typedef struct packed {
    logic             alloc;
    logic             free;
    logic [IDX_W-1:0] idx;
  } slot_upd_t;

  // slot tracker view
  typedef struct packed {
    logic              ent_valid;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [MARK_W-1:0] mark;
  } slot_stat_t;

endpackage

[hdl/stpu_desc_ram.sv]
`timescale 1ns / 1ps

module stpu_desc_ram (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [stpu_pkg::IDX_W-1:0]     waddr_i,
  input  stpu_pkg::desc_t                wdata_i,
  input  logic                           re_i,
  input  logic [stpu_pkg::IDX_W-1:0]     raddr_i,
  output stpu_pkg::desc_t                rdata_o
);

  stpu_pkg::desc_t mem_q [stpu_pkg::NUM_BLOCKS];
  stpu_pkg::desc_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/stpu_slot_ctrl.sv]
`timescale 1ns / 1ps

module stpu_slot_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stpu_pkg::slot_upd_t            upd_i,
  input  logic [stpu_pkg::IDX_W-1:0]     rd_idx_i,
  output stpu_pkg::slot_stat_t           stat_o
);

  logic [stpu_pkg::NUM_BLOCKS-1:0] valid_q, valid_d;
  logic [stpu_pkg::MARK_W-1:0]     mark_q, mark_d;
  logic                            free_found;
  logic [stpu_pkg::IDX_W-1:0]      free_idx;

  // first free slot; every slot at or above the mark is free
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = stpu_pkg::NUM_BLOCKS - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_found = 1'b1;
        free_idx   = stpu_pkg::IDX_W'(k);
      end
    end
  end

  // valid flags and high-water mark
  always_comb begin
    valid_d = valid_q;
    mark_d  = mark_q;
    if (upd_i.alloc) begin
      valid_d[upd_i.idx] = 1'b1;
      if ({1'b0, upd_i.idx} == stpu_pkg::MARK_W'(mark_q)) begin
        mark_d = mark_q + 1'b1;
      end
    end else if (upd_i.free) begin
      valid_d[upd_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      mark_q  <= '0;
    end else begin
      valid_q <= valid_d;
      mark_q  <= mark_d;
    end
  end

  assign stat_o.ent_valid  = valid_q[rd_idx_i];
  assign stat_o.free_found = free_found;
  assign stat_o.free_idx   = free_idx;
  assign stat_o.mark       = mark_q;

  // no slot at or above the mark is ever in use
  a_above_mark_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q >> mark_q) == '0)
    else $error("slot in use above high-water mark");

  // an allocated slot is in use afterwards
  a_alloc_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.alloc |=> valid_q[$past(upd_i.idx)])
    else $error("allocated slot not marked in use");

  // a freed slot is free afterwards
  a_free_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.free && !upd_i.alloc |=> !valid_q[$past(upd_i.idx)])
    else $error("freed slot still marked in use");

endmodule

[hdl/stpu_cfg.sv]
`timescale 1ns / 1ps

module stpu_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        read_check_en_o
);

  localparam logic REG_READ_CHECK = 1'b0;

  logic rce_q;
  logic wr_hit;

  // register index is the word address
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_READ_CHECK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rce_q <= 1'b0;
    end else if (wr_hit) begin
      rce_q <= pwdata[0];
    end
  end

  assign pready          = 1'b1;
  assign prdata          = (paddr[2] == REG_READ_CHECK) ? {31'd0, rce_q} : 32'd0;
  assign read_check_en_o = rce_q;

endmodule

[hdl/segment_table_protection_unit.sv]
`timescale 1ns / 1ps

// Segment descriptor table with bounds and permission checks. Each input beat carries
// a command (read check, write check, allocate, resize, change permissions, free) and
// yields exactly one result beat with a status code. Each item passes the idle state,
// which issues the registered read of the descriptor ram, and the lookup state, which
// checks, updates and writes the entry back; the input side takes no new item until
// the lookup state is done. The result register frees the input side while a result
// waits; an item only stalls in the lookup state if the previous result is not taken.
// Slot-in-use flags and the high-water mark live in flops cleared by reset, so the
// block is ready right out of reset with no clearing pass.
module segment_table_protection_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cmd[2:0], addr[34:3], block_size[47:35], mode_bits[50:48], zero pad
  input  logic [stpu_pkg::IN_W-1:0]     s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // status[1:0], block_index[7:2], offset[19:8], base_addr[37:20], zero pad
  output logic [stpu_pkg::OUT_W-1:0]    m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_e;

  localparam int A_LO = stpu_pkg::CMD_W;
  localparam int S_LO = A_LO + stpu_pkg::ADDR_W;
  localparam int M_LO = S_LO + stpu_pkg::SIZE_W;

  state_e                            state_q;
  logic                              m_tvalid_q;
  logic [stpu_pkg::OUT_W-1:0]        m_tdata_q;

  logic [stpu_pkg::CMD_W-1:0]        cmd_q;
  logic [stpu_pkg::VIDX_W-1:0]       vidx_q;
  logic [stpu_pkg::OFF_W-1:0]        off_q;
  logic [stpu_pkg::SIZE_W-1:0]       size_q;
  logic [stpu_pkg::MODE_W-1:0]       mode_q;

  logic                              in_beat;
  logic                              done;
  logic                              read_check_en;
  stpu_pkg::desc_t                   ram_rdata;
  stpu_pkg::desc_t                   ram_wdata;
  logic [stpu_pkg::IDX_W-1:0]        ram_waddr;
  logic                              ram_wr_req;
  logic                              ram_we;
  stpu_pkg::slot_upd_t               upd_req;
  stpu_pkg::slot_upd_t               slot_upd;
  stpu_pkg::slot_stat_t              slot_stat;

  logic [stpu_pkg::SIZE_W-1:0]       ent_size;
  logic [stpu_pkg::MODE_W-1:0]       ent_mode;
  logic                              outside;
  logic [stpu_pkg::STATUS_W-1:0]     res_status;
  logic [stpu_pkg::VIDX_W-1:0]       res_idx;
  logic [stpu_pkg::OFF_W-1:0]        res_off;
  logic [stpu_pkg::BASE_W-1:0]       res_base;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign done            = (state_q == S_LOOKUP) && (!m_tvalid_q || m_axis_tready_i);

  // configuration registers
  stpu_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .read_check_en_o (read_check_en)
  );

  // descriptor storage
  stpu_desc_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_beat),
    .raddr_i (s_axis_tdata_i[A_LO+stpu_pkg::OFF_W +: stpu_pkg::IDX_W]),
    .rdata_o (ram_rdata)
  );

  // in-use flags, mark and free-slot search
  stpu_slot_ctrl u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (slot_upd),
    .rd_idx_i (vidx_q[stpu_pkg::IDX_W-1:0]),
    .stat_o   (slot_stat)
  );

  // capture the input beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      cmd_q  <= s_axis_tdata_i[0 +: stpu_pkg::CMD_W];
      off_q  <= s_axis_tdata_i[A_LO +: stpu_pkg::OFF_W];
      vidx_q <= s_axis_tdata_i[A_LO+stpu_pkg::OFF_W +: stpu_pkg::VIDX_W];
      size_q <= s_axis_tdata_i[S_LO +: stpu_pkg::SIZE_W];
      mode_q <= s_axis_tdata_i[M_LO +: stpu_pkg::MODE_W];
    end
  end

  // a free slot reads as size zero, mode zero
  assign ent_size = slot_stat.ent_valid ? ram_rdata.size : '0;
  assign ent_mode = slot_stat.ent_valid ? ram_rdata.mode : '0;
  assign outside  = (vidx_q >= stpu_pkg::VIDX_W'(slot_stat.mark));

  // command evaluation and descriptor update
  always_comb begin
    res_status = stpu_pkg::ST_OK;
    res_idx    = vidx_q;
    res_off    = '0;
    res_base   = '0;
    ram_wr_req = 1'b0;
    ram_waddr  = vidx_q[stpu_pkg::IDX_W-1:0];
    ram_wdata  = ram_rdata;
    upd_req    = '0;
    upd_req.idx = vidx_q[stpu_pkg::IDX_W-1:0];
    case (cmd_q) inside
      stpu_pkg::CMD_ALLOC: begin
        res_idx = '0;
        if (!slot_stat.free_found) begin
          res_status = stpu_pkg::ST_OOM;
        end else begin
          res_idx        = stpu_pkg::VIDX_W'(slot_stat.free_idx);
          res_base       = stpu_pkg::BASE_W'({slot_stat.free_idx, stpu_pkg::OFF_W'(0)});
          ram_wr_req     = 1'b1;
          ram_waddr      = slot_stat.free_idx;
          ram_wdata.size = size_q;
          ram_wdata.mode = mode_q;
          upd_req.alloc  = 1'b1;
          upd_req.idx    = slot_stat.free_idx;
        end
      end
      stpu_pkg::CMD_RD_CHECK, stpu_pkg::CMD_WR_CHECK: begin
        res_off = off_q;
        if (outside) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else if (stpu_pkg::CMP_W'(off_q) >= stpu_pkg::CMP_W'(ent_size)) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else if (read_check_en && !ent_mode[stpu_pkg::MODE_READ]) begin
          res_status = stpu_pkg::ST_PROT;
        end else if (cmd_q == stpu_pkg::CMD_WR_CHECK && !ent_mode[stpu_pkg::MODE_WRITE]) begin
          res_status = stpu_pkg::ST_PROT;
        end
      end
      stpu_pkg::CMD_RESIZE: begin
        if (outside || !slot_stat.ent_valid) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else if (ent_mode[stpu_pkg::MODE_MAPPED] || !ent_mode[stpu_pkg::MODE_WRITE]) begin
          res_status = stpu_pkg::ST_PROT;
        end else begin
          ram_wr_req     = 1'b1;
          ram_wdata.size = size_q;
        end
      end
      stpu_pkg::CMD_CHPERM: begin
        if (outside || !slot_stat.ent_valid) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else if (ent_mode[stpu_pkg::MODE_MAPPED] || mode_q[stpu_pkg::MODE_MAPPED] ||
                     !mode_q[stpu_pkg::MODE_READ]) begin
          res_status = stpu_pkg::ST_PROT;
        end else begin
          ram_wr_req     = 1'b1;
          ram_wdata.mode = mode_q;
        end
      end
      stpu_pkg::CMD_FREE: begin
        if (outside || !slot_stat.ent_valid) begin
          res_status = stpu_pkg::ST_OUTSIDE;
        end else begin
          upd_req.free = 1'b1;
        end
      end
      default: begin
        // unused commands give an all-zero result
        res_idx = '0;
      end
    endcase
  end

  assign ram_we         = done && ram_wr_req;
  assign slot_upd.alloc = done && upd_req.alloc;
  assign slot_upd.free  = done && upd_req.free;
  assign slot_upd.idx   = upd_req.idx;

  // control state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      if (m_tvalid_q && m_axis_tready_i && !done) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            state_q <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (done) begin
            state_q    <= S_IDLE;
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= stpu_pkg::OUT_W'({res_base,
                                            stpu_pkg::OFFS_W'(res_off),
                                            stpu_pkg::BIDX_W'(res_idx),
                                            res_status});
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  // the input side is never ready straight after an accepted item
  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready_o)
    else $error("input accepted in back-to-back cycles");

  // out of memory only when every slot up to the full mark is in use
  a_oom_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && m_tdata_q[stpu_pkg::STATUS_W-1:0] == stpu_pkg::ST_OOM)
      |-> slot_stat.mark == stpu_pkg::MARK_W'(stpu_pkg::NUM_BLOCKS))
    else $error("out of memory reported below full mark");

  // a new result follows a lookup cycle
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q == S_LOOKUP))
    else $error("result appeared without a lookup");

endmodule
